FILE: rtl/pkc_pkg.sv
// ----------------------------------------------------------------------------
// pkc_pkg
// Shared types, constants and the byte mixing function of the keystream
// cipher.
// ----------------------------------------------------------------------------
package pkc_pkg;

    localparam int KeyTableDepth = 512;
    localparam int TableAddrW    = $clog2(KeyTableDepth);
    localparam int ByteW         = 8;
    localparam int LenW          = 16;
    localparam int PhaseW        = 2;
    localparam int RegAddrW      = 3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    localparam logic REG_DECRYPT_MODE = 1'b0;

    // header byte positions
    localparam logic [LenW-1:0] POS_LEN_LO = 16'd0;
    localparam logic [LenW-1:0] POS_LEN_HI = 16'd1;
    localparam logic [LenW-1:0] POS_SEED   = 16'd2;
    localparam logic [LenW-1:0] POS_HASH   = 16'd3;
    localparam logic [LenW-1:0] HDR_LEN    = 16'd4;

    // mixing step selected by position mod 4
    localparam logic [PhaseW-1:0] PH_ADD_SHL1 = 2'd0;
    localparam logic [PhaseW-1:0] PH_SUB_SHR3 = 2'd1;
    localparam logic [PhaseW-1:0] PH_ADD_SHL2 = 2'd2;
    localparam logic [PhaseW-1:0] PH_SUB_SHR5 = 2'd3;

    typedef struct packed {
        logic [ByteW-1:0]  data;
        logic              last;
        logic              header;
        logic              hash;
        logic [PhaseW-1:0] phase;
    } t_beat;

    typedef struct packed {
        logic valid;
        logic hash;
    } t_stage_status;

    function automatic logic [ByteW-1:0] mix_byte(
        input logic [ByteW-1:0]  b,
        input logic [PhaseW-1:0] phase,
        input logic [ByteW-1:0]  m,
        input logic              dec
    );
        logic [ByteW-1:0] delta;
        logic             add;
        case (phase)
            PH_ADD_SHL1: begin
                delta = {m[6:0], 1'b0};
                add   = 1'b1;
            end
            PH_SUB_SHR3: begin
                delta = {3'b000, m[7:3]};
                add   = 1'b0;
            end
            PH_ADD_SHL2: begin
                delta = {m[5:0], 2'b00};
                add   = 1'b1;
            end
            default: begin
                delta = {5'b00000, m[7:5]};
                add   = 1'b0;
            end
        endcase
        add = add ^ dec;
        return add ? (b + delta) : (b - delta);
    endfunction

endpackage

FILE: rtl/pkc_key_ram.sv
// ----------------------------------------------------------------------------
// pkc_key_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pkc_key_ram #(
    parameter int Depth = 512,
    parameter int Width = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pkc_parser.sv
// ----------------------------------------------------------------------------
// pkc_parser
// Tracks packet position, size, seed and running key; issues the key table
// read for each accepted hash or payload beat.
// ----------------------------------------------------------------------------
module pkc_parser
    import pkc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_data_accept,
    input  logic [ByteW-1:0]      i_data_byte,
    input  logic                  i_key_fwd,
    input  logic [ByteW-1:0]      i_key_data,
    output logic                  o_rd_en,
    output logic [TableAddrW-1:0] o_rd_addr,
    output t_beat                 o_beat
);

    logic [LenW-1:0]  r_pos, n_pos;
    logic [LenW-1:0]  r_len, n_len;
    logic [ByteW-1:0] r_seed, n_seed;
    logic [ByteW-1:0] r_key, n_key;

    logic [ByteW-1:0] eff_key;
    logic             is_header;
    logic             is_hash;
    logic             is_last;

    // key loaded by the hash beat is still in the read register
    assign eff_key   = i_key_fwd ? i_key_data : r_key;
    assign is_header = (r_pos < HDR_LEN);
    assign is_hash   = (r_pos == POS_HASH);

    always_comb begin
        if (is_hash) begin
            is_last = (r_len <= HDR_LEN);
        end else if (is_header) begin
            is_last = 1'b0;
        end else begin
            is_last = ({1'b0, r_pos} + 17'd1) >= {1'b0, r_len};
        end
    end

    assign o_rd_en   = i_data_accept && (is_hash || !is_header);
    assign o_rd_addr = is_hash ? {r_seed, 1'b0} : {eff_key, 1'b1};

    assign o_beat.data   = i_data_byte;
    assign o_beat.last   = is_last;
    assign o_beat.header = is_header;
    assign o_beat.hash   = is_hash;
    assign o_beat.phase  = r_pos[PhaseW-1:0];

    always_comb begin
        n_pos  = r_pos;
        n_len  = r_len;
        n_seed = r_seed;
        n_key  = i_key_fwd ? i_key_data : r_key;
        if (i_data_accept) begin
            n_pos = is_last ? '0 : (r_pos + 16'd1);
            if (r_pos == POS_LEN_LO) begin
                n_len = {r_len[15:8], i_data_byte};
            end
            if (r_pos == POS_LEN_HI) begin
                n_len = {i_data_byte, r_len[7:0]};
            end
            if (r_pos == POS_SEED) begin
                n_seed = i_data_byte;
            end
            if (!is_header) begin
                n_key = eff_key + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_seed <= '0;
            r_key  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_seed <= n_seed;
            r_key  <= n_key;
        end
    end

endmodule

FILE: rtl/pkc_mix_stage.sv
// ----------------------------------------------------------------------------
// pkc_mix_stage
// Holds a packet beat beside its table read data, mixes the byte and drives
// the output register.
// ----------------------------------------------------------------------------
module pkc_mix_stage
    import pkc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_beat            i_beat,
    input  logic [ByteW-1:0] i_rd_data,
    input  logic             i_decrypt,
    input  logic             i_out_stall,
    output logic             o_ready,
    output t_stage_status    o_status,
    output logic             o_valid,
    output logic [ByteW-1:0] o_out_byte,
    output logic             o_last_of_packet,
    output logic             o_header_byte
);

    logic             r_b_valid, n_b_valid;
    t_beat            r_b_beat;
    logic             r_o_valid, n_o_valid;
    logic [ByteW-1:0] r_o_byte;
    logic             r_o_last;
    logic             r_o_header;

    logic             out_free;
    logic             b_move;
    logic [ByteW-1:0] mixed;

    assign out_free = !r_o_valid || !i_out_stall;
    assign b_move   = r_b_valid && out_free;
    assign o_ready  = !r_b_valid || out_free;

    assign mixed = r_b_beat.header ? r_b_beat.data
                 : mix_byte(r_b_beat.data, r_b_beat.phase, i_rd_data, i_decrypt);

    always_comb begin
        n_b_valid = r_b_valid;
        if (i_load) begin
            n_b_valid = 1'b1;
        end else if (b_move) begin
            n_b_valid = 1'b0;
        end
        n_o_valid = out_free ? r_b_valid : r_o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_b_valid <= n_b_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b_beat <= i_beat;
        end
        if (b_move) begin
            r_o_byte   <= mixed;
            r_o_last   <= r_b_beat.last;
            r_o_header <= r_b_beat.header;
        end
    end

    assign o_status.valid   = r_b_valid;
    assign o_status.hash    = r_b_beat.hash;
    assign o_valid          = r_o_valid;
    assign o_out_byte       = r_o_byte;
    assign o_last_of_packet = r_o_last;
    assign o_header_byte    = r_o_header;

endmodule

FILE: rtl/packet_keystream_cipher.sv
// ----------------------------------------------------------------------------
// packet_keystream_cipher
// Table-keyed byte cipher over a packet stream.
//
// Input channel (i_valid / o_stall): each beat either writes one key table
// byte (i_action = 0) or presents one packet byte (i_action = 1). Packets
// open with a 4-byte header (size LSB, size MSB, seed, hash) that passes
// through unchanged; later bytes are mixed with the key table.
// Output channel (o_valid / i_stall): one beat per packet byte, none per
// table write. o_last_of_packet marks the final byte, o_header_byte the
// four header bytes.
// A packet byte is registered in the mix stage, then in the output register.
// Throughput: one beat per cycle while o_stall is low. The key table is a RAM
// with one write and one registered read port; each beat uses at most one.
// A key table entry must be written before it is read.
// Reset: packet tracking, running key and decrypt_mode clear; the key table
// keeps its contents.
// Stall: the output register holds; one beat more is absorbed in the mix
// stage, after which o_stall rises.
// decrypt_mode sits at APB address 0x0.
// ----------------------------------------------------------------------------
module packet_keystream_cipher
    import pkc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_action,
    input  logic [TableAddrW-1:0] i_table_index,
    input  logic [ByteW-1:0]      i_table_value,
    input  logic [ByteW-1:0]      i_data_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ByteW-1:0]      o_out_byte,
    output logic                  o_last_of_packet,
    output logic                  o_header_byte,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [RegAddrW-1:0]   paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                  r_decrypt;
    logic                  in_accept;
    logic                  data_accept;
    logic                  ram_we;
    logic                  ram_re;
    logic [TableAddrW-1:0] ram_raddr;
    logic [ByteW-1:0]      ram_rdata;
    logic                  stage_ready;
    t_stage_status         stage_status;
    t_beat                 beat;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
        end else if (cfg_write && (paddr[2] == REG_DECRYPT_MODE)) begin
            r_decrypt <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_DECRYPT_MODE) ? {31'd0, r_decrypt} : 32'd0;

    assign o_stall     = !stage_ready;
    assign in_accept   = i_valid && !o_stall;
    assign data_accept = in_accept && (i_action == ACT_DATA);
    assign ram_we      = in_accept && (i_action == ACT_WRITE);

    pkc_key_ram #(
        .Depth (KeyTableDepth),
        .Width (ByteW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pkc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_accept (data_accept),
        .i_data_byte   (i_data_byte),
        .i_key_fwd     (stage_status.valid && stage_status.hash),
        .i_key_data    (ram_rdata),
        .o_rd_en       (ram_re),
        .o_rd_addr     (ram_raddr),
        .o_beat        (beat)
    );

    pkc_mix_stage u_mix (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (data_accept),
        .i_beat           (beat),
        .i_rd_data        (ram_rdata),
        .i_decrypt        (r_decrypt),
        .i_out_stall      (i_stall),
        .o_ready          (stage_ready),
        .o_status         (stage_status),
        .o_valid          (o_valid),
        .o_out_byte       (o_out_byte),
        .o_last_of_packet (o_last_of_packet),
        .o_header_byte    (o_header_byte)
    );

    a_ram_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("key table read and write in the same cycle");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(stage_status.valid))
        else $error("output beat without a beat in the mix stage");

    a_no_back_to_back_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_status.valid && stage_status.hash && data_accept) |-> !beat.hash)
        else $error("hash beat follows hash beat");

endmodule

FILE: test/packet_keystream_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_keystream_cipher_tb
// Drives key table writes and packet bytes into the cipher, predicts every
// output beat from a local model of the key table and packet tracking, and
// compares outputs in order. Input gaps and output stalls are random by phase,
// the decrypt mode changes between phases, and one packet spans a mode change.
// ----------------------------------------------------------------------------
module packet_keystream_cipher_tb;
    import pkc_pkg::*;

    typedef struct {
        logic                  action;
        logic [TableAddrW-1:0] index;
        logic [ByteW-1:0]      value;
        logic [ByteW-1:0]      data;
    } t_cipher_in;

    typedef struct {
        logic [ByteW-1:0] out_byte;
        logic             last;
        logic             header;
    } t_cipher_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_action = ACT_WRITE;
    logic [TableAddrW-1:0] i_table_index = '0;
    logic [ByteW-1:0]      i_table_value = '0;
    logic [ByteW-1:0]      i_data_byte = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [ByteW-1:0]      o_out_byte;
    logic                  o_last_of_packet;
    logic                  o_header_byte;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [RegAddrW-1:0]   paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    packet_keystream_cipher dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [ByteW-1:0] key_tab [KeyTableDepth];
    logic [LenW-1:0]  pkt_pos = '0;
    logic [LenW-1:0]  pkt_len = '0;
    logic [ByteW-1:0] pkt_seed = '0;
    logic [ByteW-1:0] run_key = '0;
    logic             dec_mode = 1'b0;

    // stimulus generator shadow of the key table
    logic [ByteW-1:0] gen_tab [KeyTableDepth];
    bit               gen_written [KeyTableDepth];

    t_cipher_in  beat_q [$];
    t_cipher_out pending_out_q [$];
    t_cipher_in  cur_beat;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int wr_mix_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int items_made = 0;
    int pkt_cnt = 0;
    int wr_cnt = 0;
    int results_seen = 0;
    int in_stall_cycles = 0;
    int err_cnt = 0;

    function automatic void note_err(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void cipher_predict(input t_cipher_in it);
        t_cipher_out      r;
        logic [ByteW-1:0] m;
        logic [ByteW-1:0] delta;
        logic             add;
        logic [LenW-1:0]  p;
        if (it.action == ACT_WRITE) begin
            key_tab[it.index] = it.value;
            return;
        end
        p = pkt_pos;
        r.out_byte = it.data;
        r.header = 1'b1;
        r.last = 1'b0;
        if (p == POS_LEN_LO) begin
            pkt_len = {8'd0, it.data};
        end else if (p == POS_LEN_HI) begin
            pkt_len[15:8] = it.data;
        end else if (p == POS_SEED) begin
            pkt_seed = it.data;
        end else if (p == POS_HASH) begin
            run_key = key_tab[{pkt_seed, 1'b0}];
            r.last = (pkt_len <= HDR_LEN);
        end else begin
            m = key_tab[{run_key, 1'b1}];
            case (p[1:0])
                PH_ADD_SHL1: begin delta = m << 1; add = 1'b1; end
                PH_SUB_SHR3: begin delta = m >> 3; add = 1'b0; end
                PH_ADD_SHL2: begin delta = m << 2; add = 1'b1; end
                default:     begin delta = m >> 5; add = 1'b0; end
            endcase
            if (dec_mode)
                add = !add;
            r.out_byte = add ? it.data + delta : it.data - delta;
            r.header = 1'b0;
            run_key = run_key + 8'd1;
            r.last = ({1'b0, p} + 17'd1 >= {1'b0, pkt_len});
        end
        pkt_pos = r.last ? '0 : p + 16'd1;
        pending_out_q.insert(pending_out_q.size(), r);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                cipher_predict(cur_beat);
            if (i_valid && o_stall) begin
                in_stall_cycles++;
            end else if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_beat = beat_q.pop_front();
                i_action <= cur_beat.action;
                i_table_index <= cur_beat.index;
                i_table_value <= cur_beat.value;
                i_data_byte <= cur_beat.data;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = 400;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cipher_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_out_q.size() == 0) begin
                note_err($sformatf("unexpected beat byte=%02h last=%0b hdr=%0b",
                    o_out_byte, o_last_of_packet, o_header_byte));
            end else begin
                e = pending_out_q.pop_front();
                results_seen++;
                if (o_out_byte !== e.out_byte || o_last_of_packet !== e.last ||
                        o_header_byte !== e.header)
                    note_err($sformatf("exp byte=%02h last=%0b hdr=%0b, got %02h %0b %0b",
                        e.out_byte, e.last, e.header,
                        o_out_byte, o_last_of_packet, o_header_byte));
            end
        end
    end

    task automatic push_write(input int idx, input int val);
        t_cipher_in it;
        it.action = ACT_WRITE;
        it.index = idx[TableAddrW-1:0];
        it.value = val[ByteW-1:0];
        it.data = ByteW'($urandom);
        beat_q.insert(beat_q.size(), it);
        gen_tab[idx] = val[ByteW-1:0];
        gen_written[idx] = 1'b1;
        items_made++;
        wr_cnt++;
    endtask

    task automatic need_entry(input int idx);
        if (!gen_written[idx])
            push_write(idx, $urandom_range(255));
    endtask

    task automatic push_byte(input logic [ByteW-1:0] b);
        t_cipher_in it;
        if ($urandom_range(99) < wr_mix_pct)
            push_write($urandom_range(KeyTableDepth - 1), $urandom_range(255));
        it.action = ACT_DATA;
        it.index = TableAddrW'($urandom);
        it.value = ByteW'($urandom);
        it.data = b;
        beat_q.insert(beat_q.size(), it);
        items_made++;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (beat_q.size() != 0 || i_valid || pending_out_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_DECRYPT_MODE, 2'b00};
        pwdata <= {31'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dec_mode = v;
        @(negedge i_clk);
    endtask

    // split > 0: stop after that many payload bytes, flip the mode, go on
    task automatic send_packet(input int size, input int seed, input int split);
        logic [ByteW-1:0] k;
        int               n;
        push_byte(size[7:0]);
        push_byte(size[15:8]);
        push_byte(seed[7:0]);
        need_entry(2 * seed);
        push_byte(ByteW'($urandom));
        k = gen_tab[2 * seed];
        n = (size > 4) ? size - 4 : 0;
        for (int i = 0; i < n; i++) begin
            if (split != 0 && i == split) begin
                drain();
                set_mode(!dec_mode);
            end
            need_entry(2 * k + 1);
            push_byte(ByteW'($urandom));
            k = k + 8'd1;
        end
        pkt_cnt++;
    endtask

    task automatic random_items(input int n);
        int target;
        int r;
        int size;
        target = items_made + n;
        while (items_made < target) begin
            r = $urandom_range(99);
            if (r < 8)
                size = $urandom_range(4);
            else if (r < 80)
                size = $urandom_range(40, 5);
            else if (r < 95)
                size = $urandom_range(120, 41);
            else
                size = $urandom_range(700, 256);
            send_packet(size, $urandom_range(255), 0);
        end
    endtask

    initial begin
        int guard;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_mode(1'b0);

        // directed
        push_write(0, 0);
        push_write(KeyTableDepth - 1, 255);
        push_write(1, 255);
        for (int s = 0; s <= 5; s++)
            send_packet(s, (s == 5) ? 255 : 0, 0);
        send_packet(8, 255, 0);
        push_write(2 * 17, 8'hFD);
        send_packet(14, 17, 0);
        send_packet(24, $urandom_range(255), 7);
        send_packet(16'h0105, $urandom_range(255), 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            wr_mix_pct = 10;
            set_mode((ph % 2) == 0);
            if (ph == 0)
                hold_req++;
            if (ph == 1) begin
                random_items(150);
                drain();
                random_items(150);
            end else begin
                random_items(300);
            end
            if (ph < 3)
                drain();
        end

        do @(negedge i_clk);
        while (beat_q.size() != 0 || i_valid);
        guard = 0;
        while (pending_out_q.size() != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (10) @(negedge i_clk);
        if (pending_out_q.size() != 0)
            note_err($sformatf("%0d expected beats never arrived", pending_out_q.size()));

        $display("covered %0d packets (sizes 0..700) and %0d key writes, both modes",
            pkt_cnt, wr_cnt);
        $display("checked %0d output beats; input held off %0d cycles; %0d mismatches",
            results_seen, in_stall_cycles, err_cnt);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #1_500_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
